/* rtl/lscc_pkg.sv */
// Shared types, constants and helpers for the link speed code converter.
// No dependencies; used by every module in rtl/.
package lscc_pkg;

  localparam int SPEED_W     = 32;  // raw speed input width
  localparam int CODE_W      = 8;   // speed code width
  localparam int X_W         = 29;  // working speed width (range checked value)
  localparam int E_W         = 3;   // exponent width
  localparam int MANT_W      = 5;   // mantissa-minus-one width
  localparam int POW_W       = 24;  // holds 10^7
  localparam int DEC_W       = 29;  // decoded speed width
  localparam int STEPS       = 7;   // divide-by-ten iterations
  localparam int RECIP_W     = 32;
  localparam int PROD_W      = X_W + RECIP_W;
  localparam int RECIP_SHIFT = 35;

  localparam logic [SPEED_W-1:0] SPEED_MAX  = 32'd320000000;
  localparam logic [X_W-1:0]     MANT_LIMIT = 29'd32;
  localparam logic [E_W-1:0]     EXP_MAX    = 3'd7;
  // ceil(2^35 / 10): exact floor(x/10) for any 32-bit x
  localparam logic [RECIP_W-1:0] RECIP      = 32'hCCCCCCCD;

  localparam logic CMD_ENCODE = 1'b0;
  localparam logic CMD_DECODE = 1'b1;

  // One conversion in flight
  typedef struct packed {
    logic             cmd;
    logic             bad;   // zero or out-of-range speed
    logic [X_W-1:0]   x;     // speed being reduced
    logic [E_W-1:0]   e;     // exponent so far
    logic [DEC_W-1:0] dec;   // decoded speed
  } item_t;

  function automatic logic [POW_W-1:0] pow10(input logic [E_W-1:0] e);
    logic [POW_W-1:0] p;
    unique case (e)
      3'd0: p = 24'd1;
      3'd1: p = 24'd10;
      3'd2: p = 24'd100;
      3'd3: p = 24'd1000;
      3'd4: p = 24'd10000;
      3'd5: p = 24'd100000;
      3'd6: p = 24'd1000000;
      3'd7: p = 24'd10000000;
      default: p = 24'd0;
    endcase
    return p;
  endfunction

endpackage

/* rtl/lscc_front.sv */
// Entry stage: range check of the speed and full decode of the code.
// Depends on lscc_pkg.
module lscc_front (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_vld,
  input  logic                          cmd,
  input  logic [lscc_pkg::SPEED_W-1:0]  speed_in,
  input  logic [lscc_pkg::CODE_W-1:0]   code_in,
  output logic                          out_vld,
  output lscc_pkg::item_t               out_item
);

  logic [lscc_pkg::MANT_W:0]     mant;
  logic [lscc_pkg::POW_W-1:0]    scale;
  logic [lscc_pkg::MANT_W+lscc_pkg::POW_W:0] prod;

  assign mant  = {1'b0, code_in[lscc_pkg::CODE_W-1:lscc_pkg::E_W]} + 6'd1;
  assign scale = lscc_pkg::pow10(code_in[lscc_pkg::E_W-1:0]);
  assign prod  = 30'(mant) * 30'(scale);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else begin
      out_vld <= in_vld;
    end
    out_item.cmd <= cmd;
    out_item.bad <= (speed_in == '0) || (speed_in > lscc_pkg::SPEED_MAX);
    out_item.x   <= speed_in[lscc_pkg::X_W-1:0];
    out_item.e   <= '0;
    out_item.dec <= prod[lscc_pkg::DEC_W-1:0];
  end

endmodule

/* rtl/lscc_div10_step.sv */
// One reduction iteration over two stages: quotient by reciprocal multiply,
// then remainder test and conditional update. Depends on lscc_pkg.
module lscc_div10_step (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_vld,
  input  lscc_pkg::item_t  in_item,
  output logic             out_vld,
  output lscc_pkg::item_t  out_item
);

  logic [lscc_pkg::PROD_W-1:0] prod;
  logic                        a_vld;
  lscc_pkg::item_t             a_item;
  logic [lscc_pkg::X_W-1:0]    a_q;
  logic [lscc_pkg::X_W-1:0]    q10;
  logic                        step;
  lscc_pkg::item_t             out_item_next;

  assign prod = lscc_pkg::PROD_W'(in_item.x) * lscc_pkg::PROD_W'(lscc_pkg::RECIP);

  // stage A: quotient
  always_ff @(posedge clk) begin
    if (rst) begin
      a_vld <= 1'b0;
    end else begin
      a_vld <= in_vld;
    end
    a_item <= in_item;
    a_q    <= lscc_pkg::X_W'(prod[lscc_pkg::PROD_W-1:lscc_pkg::RECIP_SHIFT]);
  end

  // q*10 by shift-add; divisible when it equals x
  assign q10  = lscc_pkg::X_W'({a_q, 3'b000}) + lscc_pkg::X_W'({a_q, 1'b0});
  assign step = (a_item.x > lscc_pkg::MANT_LIMIT) ||
                ((a_item.x == q10) && (a_item.e != lscc_pkg::EXP_MAX));

  always_comb begin
    out_item_next   = a_item;
    out_item_next.x = step ? a_q : a_item.x;
    out_item_next.e = a_item.e + lscc_pkg::E_W'(step);
  end

  // stage B: apply
  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else begin
      out_vld <= a_vld;
    end
    out_item <= out_item_next;
  end

endmodule

/* rtl/link_speed_code_converter_top.sv */
// Top level of the link speed code converter.
// Depends on lscc_pkg, lscc_front and lscc_div10_step.
//
// Converts one item per clock between a 32-bit link speed and an 8-bit speed
// code (bits 7..3 mantissa minus one, bits 2..0 power-of-ten exponent). A
// transfer is taken at every rising edge where start is high; busy is always
// low. Each result appears on code_out/speed_out for one cycle with done high,
// in order. On its way it passes the entry stage, seven divide-by-ten
// iterations of two stages each (reciprocal multiply, then remainder test) and
// the output register. The receiver cannot stall, so there is no back-pressure
// anywhere in the pipe.
// Encoding yields code 0 for a speed of zero or above 320000000; the unused
// output of each command reads 0.
module link_speed_code_converter_top (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic                          cmd,
  input  logic [lscc_pkg::SPEED_W-1:0]  speed_in,
  input  logic [lscc_pkg::CODE_W-1:0]   code_in,
  output logic                          done,
  output logic [lscc_pkg::CODE_W-1:0]   code_out,
  output logic [lscc_pkg::DEC_W-1:0]    speed_out
);

  // pipeline taps: index 0 after entry, index i after iteration i
  logic            vld_c  [0:lscc_pkg::STEPS];
  lscc_pkg::item_t item_c [0:lscc_pkg::STEPS];

  logic            acc;
  logic [5:0]      mant_m1;
  lscc_pkg::item_t fin;
  logic            enc_ok;

  // never stalls
  assign busy = 1'b0;
  assign acc  = start && !busy;

  lscc_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_vld   (acc),
    .cmd      (cmd),
    .speed_in (speed_in),
    .code_in  (code_in),
    .out_vld  (vld_c[0]),
    .out_item (item_c[0])
  );

  for (genvar i = 0; i < lscc_pkg::STEPS; i++) begin : g_step
    lscc_div10_step u_step (
      .clk      (clk),
      .rst      (rst),
      .in_vld   (vld_c[i]),
      .in_item  (item_c[i]),
      .out_vld  (vld_c[i+1]),
      .out_item (item_c[i+1])
    );
  end

  // after seven iterations x is in 1..32 for any valid speed
  assign fin     = item_c[lscc_pkg::STEPS];
  assign mant_m1 = fin.x[5:0] - 6'd1;
  assign enc_ok  = (fin.cmd == lscc_pkg::CMD_ENCODE) && !fin.bad;

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= vld_c[lscc_pkg::STEPS];
    end
    code_out  <= enc_ok ? {mant_m1[lscc_pkg::MANT_W-1:0], fin.e} : '0;
    speed_out <= (fin.cmd == lscc_pkg::CMD_DECODE) ? fin.dec : '0;
  end

endmodule

/* rtl/lscc_checker.sv */
// Port-level checks for the link speed code converter, with bind.
// Depends on lscc_pkg; attaches to link_speed_code_converter_top.
module lscc_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          start,
  input logic                          busy,
  input logic                          cmd,
  input logic [lscc_pkg::SPEED_W-1:0]  speed_in,
  input logic [lscc_pkg::CODE_W-1:0]   code_in,
  input logic                          done,
  input logic [lscc_pkg::CODE_W-1:0]   code_out,
  input logic [lscc_pkg::DEC_W-1:0]    speed_out
);

  // cycles since reset, saturating once the pipe has fully refilled
  logic [4:0] since_rst;
  logic       settled;

  always_ff @(posedge clk) begin
    if (rst) begin
      since_rst <= '0;
    end else if (since_rst != 5'd16) begin
      since_rst <= since_rst + 5'd1;
    end
  end

  assign settled = (since_rst == 5'd16);

  a_no_busy: assert property (@(posedge clk) disable iff (rst) !busy)
    else $error("busy asserted");

  a_latency: assert property (@(posedge clk) disable iff (rst)
    settled |-> (done == $past(start, 16)))
    else $error("result strobe not 16 cycles after start");

  a_one_side: assert property (@(posedge clk) disable iff (rst)
    done |-> ((code_out == '0) || (speed_out == '0)))
    else $error("both result fields nonzero");

  a_zero_speed: assert property (@(posedge clk) disable iff (rst)
    (settled && $past(start && (cmd == lscc_pkg::CMD_ENCODE) && (speed_in == '0), 16))
      |-> (done && (code_out == '0)))
    else $error("zero speed did not encode to code 0");

  a_min_code: assert property (@(posedge clk) disable iff (rst)
    (settled && $past(start && (cmd == lscc_pkg::CMD_DECODE) && (code_in == '0), 16))
      |-> (done && (speed_out == 29'd1)))
    else $error("code 0 did not decode to 1");

endmodule

bind link_speed_code_converter_top lscc_checker u_lscc_checker (.*);

/* bench/link_speed_code_converter_top_tb.sv */
`timescale 1ns / 100ps
// Self-checking bench for link_speed_code_converter_top: directed and random
// encode/decode transfers checked against a local predictor.
// Depends on lscc_pkg and the converter RTL.
module link_speed_code_converter_top_tb;

  // Drain time, with margin on top of the start-to-done latency.
  localparam int DRAIN_CYCLES  = 40;
  localparam int RANDOM_ITEMS  = 1700;
  localparam int BLOCK_ITEMS   = 100;
  localparam int MANT_TOP      = 32;
  localparam int EXP_TOP       = 7;

  // Expected result of one conversion
  typedef struct {
    logic [lscc_pkg::CODE_W-1:0] code;
    logic [lscc_pkg::DEC_W-1:0]  speed;
  } conversion_t;

  logic                          clk = 1'b0;
  logic                          rst = 1'b1;
  logic                          start = 1'b0;
  logic                          busy;
  logic                          cmd = lscc_pkg::CMD_ENCODE;
  logic [lscc_pkg::SPEED_W-1:0]  speed_in = '0;
  logic [lscc_pkg::CODE_W-1:0]   code_in = '0;
  logic                          done;
  logic [lscc_pkg::CODE_W-1:0]   code_out;
  logic [lscc_pkg::DEC_W-1:0]    speed_out;

  conversion_t pending_conversions[$];
  int          error_count = 0;

  link_speed_code_converter_top dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .cmd       (cmd),
    .speed_in  (speed_in),
    .code_in   (code_in),
    .done      (done),
    .code_out  (code_out),
    .speed_out (speed_out)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // Speed to code: strip digits while too wide for the mantissa, or while a
  // trailing zero remains and the exponent has room left (caps at 7).
  function automatic logic [lscc_pkg::CODE_W-1:0] encode_link_speed(
      input logic [lscc_pkg::SPEED_W-1:0] speed);
    logic [lscc_pkg::SPEED_W-1:0] v;
    int                           e;
    logic [lscc_pkg::MANT_W-1:0]  mant;
    if (speed == '0 || speed > lscc_pkg::SPEED_MAX) begin
      return '0;
    end
    v = speed;
    e = 0;
    while (v > MANT_TOP || ((v % 10) == 0 && e < EXP_TOP)) begin
      v = v / 10;
      e++;
    end
    mant = v[lscc_pkg::MANT_W-1:0] - 5'd1;
    return {mant, e[lscc_pkg::E_W-1:0]};
  endfunction

  // Code to speed: (mantissa + 1) * 10^exponent, at most 320000000.
  function automatic logic [lscc_pkg::DEC_W-1:0] decode_speed_code(
      input logic [lscc_pkg::CODE_W-1:0] code);
    logic [lscc_pkg::SPEED_W-1:0] v;
    v = {27'd0, code[lscc_pkg::CODE_W-1 -: lscc_pkg::MANT_W]} + 32'd1;
    repeat (code[lscc_pkg::E_W-1:0]) v = v * 10;
    return v[lscc_pkg::DEC_W-1:0];
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $time);
    error_count++;
  endtask

  // ---------------------------------------------------------------------------
  // Scoreboard: one process samples both handshakes at each rising edge.
  // Results are compared before the new transfer is queued, so the order is
  // fixed within the edge.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    conversion_t want;
    conversion_t fresh;
    if (!rst) begin
      if (done) begin
        if (pending_conversions.size() == 0) begin
          report_mismatch("result with nothing pending, code_out", code_out, 0);
        end else begin
          want = pending_conversions.pop_front();
          if (code_out !== want.code) begin
            report_mismatch("code_out", code_out, want.code);
          end
          if (speed_out !== want.speed) begin
            report_mismatch("speed_out", speed_out, want.speed);
          end
        end
      end
      if (start && !busy) begin
        if (cmd == lscc_pkg::CMD_ENCODE) begin
          fresh.code  = encode_link_speed(speed_in);
          fresh.speed = '0;
        end else begin
          fresh.code  = '0;
          fresh.speed = decode_speed_code(code_in);
        end
        pending_conversions.push_back(fresh);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  // Idle cycles ahead of a transfer: mostly none or short, a few long.
  function automatic int pick_gap(input bit no_idle);
    int r;
    if (no_idle) begin
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 55) begin
      return 0;
    end else if (r < 90) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 40);
  endfunction

  // Called right after a rising edge; returns right after the edge that took
  // the transfer. start stays high so back-to-back transfers need no toggle.
  task automatic send_conversion(input logic op, input logic [lscc_pkg::SPEED_W-1:0] speed,
                                 input logic [lscc_pkg::CODE_W-1:0] code, input int gap);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start    <= 1'b1;
    cmd      <= op;
    speed_in <= speed;
    code_in  <= code;
    do @(posedge clk); while (busy);
  endtask

  task automatic send_encode(input logic [lscc_pkg::SPEED_W-1:0] speed);
    send_conversion(lscc_pkg::CMD_ENCODE, speed, lscc_pkg::CODE_W'($urandom),
                    pick_gap(1'b0));
  endtask

  task automatic send_decode(input logic [lscc_pkg::CODE_W-1:0] code);
    send_conversion(lscc_pkg::CMD_DECODE, $urandom, code, pick_gap(1'b0));
  endtask

  // Speed mix: exact codes, in-range values of every magnitude, noise above
  // the range, and the boundaries.
  function automatic logic [lscc_pkg::SPEED_W-1:0] pick_speed();
    int                           r;
    logic [lscc_pkg::SPEED_W-1:0] v;
    r = $urandom_range(0, 99);
    if (r < 15) begin
      v = $urandom_range(1, MANT_TOP);
      repeat ($urandom_range(0, EXP_TOP)) v = v * 10;
    end else if (r < 55) begin
      v = $urandom_range(1, lscc_pkg::SPEED_MAX);
    end else if (r < 70) begin
      v = $urandom_range(1, 1000);
    end else if (r < 85) begin
      v = $urandom >> $urandom_range(0, 31);
    end else if (r < 95) begin
      v = $urandom;
    end else begin
      case ($urandom_range(0, 2))
        0: v = '0;
        1: v = lscc_pkg::SPEED_MAX;
        default: v = lscc_pkg::SPEED_MAX + 1;
      endcase
    end
    return v;
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Zero, range limits, mantissa boundary, full-scale input
  task automatic test_encode_limits();
    send_encode(32'd0);
    send_encode(32'd1);
    send_encode(32'd32);
    send_encode(32'd33);
    send_encode(32'd330);
    send_encode(lscc_pkg::SPEED_MAX);
    send_encode(lscc_pkg::SPEED_MAX + 1);
    send_encode(32'hFFFF_FFFF);
    send_encode(32'd123456789);
  endtask

  // Trailing zeros past exponent 7 must stay in the mantissa
  task automatic test_exponent_cap();
    send_encode(32'd10000000);
    send_encode(32'd100000000);
    send_encode(32'd200000000);
    send_encode(32'd300000000);
    send_encode(32'd310);
  endtask

  // Code extremes and exponents 0, 2, 3, 4, 5 and 7
  task automatic test_decode_limits();
    send_decode(8'h00);
    send_decode(8'hFF);
    send_decode(8'hF8);
    send_decode(8'h07);
    send_decode(8'h55);
    send_decode(8'hAA);
    send_decode(8'h0B);
    send_decode(8'h7C);
  endtask

  // Mixed random traffic; about one block in four, chosen at random, runs with no idle cycles.
  task automatic test_random_traffic();
    bit no_idle;
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i % BLOCK_ITEMS == 0) begin
        no_idle = ($urandom_range(0, 3) == 0);
      end
      if ($urandom_range(0, 99) < 40) begin
        send_conversion(lscc_pkg::CMD_DECODE, $urandom, lscc_pkg::CODE_W'($urandom),
                        pick_gap(no_idle));
      end else begin
        send_conversion(lscc_pkg::CMD_ENCODE, pick_speed(), lscc_pkg::CODE_W'($urandom),
                        pick_gap(no_idle));
      end
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_encode_limits();
    test_exponent_cap();
    test_decode_limits();
    test_random_traffic();
    start <= 1'b0;
    // Drain, then watch a little longer for stray results
    while (pending_conversions.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (pending_conversions.size() != 0) begin
      report_mismatch("results never delivered", pending_conversions.size(), 0);
    end
    if (error_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run (every gap at its longest)
  initial begin
    #5_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule
